FILE: design/ufd_pkg.sv
package ufd_pkg;

  // Input item: one frame byte and its end-of-frame flag.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LENGTH  = 3'd1,
    ST_BAD_START   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_END     = 3'd4,
    ST_BAD_CRC     = 3'd5
  } status_e;

  // Result item: a payload byte or the end-of-frame summary.
  typedef struct packed {
    logic        is_summary;
    status_e     status;
    logic [7:0]  msg_type;
    logic [7:0]  frame_flags;
    logic [15:0] sequence_res;
    logic [31:0] session;
    logic [31:0] device;
    logic [15:0] endpoint_number;
    logic [31:0] binding_rev;
    logic [31:0] cluster_code;
    logic [31:0] item_code;
    logic [7:0]  payload_byte;
  } out_item_t;

  // Expected framing bytes, from the register file.
  typedef struct packed {
    logic [7:0] start_byte_0;
    logic [7:0] start_byte_1;
    logic [7:0] protocol_version;
    logic [7:0] end_byte_0;
    logic [7:0] end_byte_1;
  } cfg_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_START_BYTE_0     = 3'd0;
  localparam logic [2:0] REG_START_BYTE_1     = 3'd1;
  localparam logic [2:0] REG_PROTOCOL_VERSION = 3'd2;
  localparam logic [2:0] REG_END_BYTE_0       = 3'd3;
  localparam logic [2:0] REG_END_BYTE_1       = 3'd4;

  localparam int unsigned POS_W = 11;
  localparam logic [POS_W-1:0] POS_MAX       = 11'd2047;
  localparam logic [POS_W-1:0] OFS_START_0   = 11'd0;
  localparam logic [POS_W-1:0] OFS_START_1   = 11'd1;
  localparam logic [POS_W-1:0] OFS_VERSION   = 11'd2;
  localparam logic [POS_W-1:0] OFS_LEN_LO    = 11'd29;
  localparam logic [POS_W-1:0] OFS_LEN_HI    = 11'd30;
  localparam logic [POS_W-1:0] OFS_PAYLOAD   = 11'd31;
  // Byte leaving the four-deep tail window sits at offset 2 when pos is 6.
  localparam logic [POS_W-1:0] OFS_CRC_START = 11'd6;
  // Last-byte position of the shortest legal frame (35 bytes).
  localparam logic [POS_W-1:0] MIN_LAST_POS  = 11'd34;

  localparam int unsigned HDR_LO = 3;
  localparam int unsigned HDR_HI = 28;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // CRC16-CCITT-FALSE, one byte, MSB first, unrolled.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: design/ufd_apb_regs.sv
module ufd_apb_regs import ufd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_BYTE_0:     cfg_q.start_byte_0     <= pwdata[7:0];
        REG_START_BYTE_1:     cfg_q.start_byte_1     <= pwdata[7:0];
        REG_PROTOCOL_VERSION: cfg_q.protocol_version <= pwdata[7:0];
        REG_END_BYTE_0:       cfg_q.end_byte_0       <= pwdata[7:0];
        REG_END_BYTE_1:       cfg_q.end_byte_1       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_START_BYTE_0:     prdata[7:0] = cfg_q.start_byte_0;
      REG_START_BYTE_1:     prdata[7:0] = cfg_q.start_byte_1;
      REG_PROTOCOL_VERSION: prdata[7:0] = cfg_q.protocol_version;
      REG_END_BYTE_0:       prdata[7:0] = cfg_q.end_byte_0;
      REG_END_BYTE_1:       prdata[7:0] = cfg_q.end_byte_1;
      default:              prdata      = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/uart_frame_deframer_crc16.sv
// Streaming frame deframer with CRC16-CCITT-FALSE check. One frame byte per
// item, with last_byte set on the frame's final byte. Frame layout: two start
// bytes, a version byte, header offsets 3..28 (little-endian fields), a 16-bit
// payload length L at offsets 29..30, L payload bytes, a CRC over offsets
// 2..30+L (little-endian), then two end bytes. Every payload byte that does
// not end the frame is passed out as a result item with is_summary = 0, even
// if the frame later fails. The byte that ends the frame yields one summary
// item; its status follows the priority: short frame or a frame long enough to
// saturate the position counter at 2047, start bytes, version, length (L above
// MAX_PAYLOAD, 1024 by default, or frame size not 35 + L), end bytes, CRC.
// Header fields are non-zero only when the status is ok. Expected start,
// version and end bytes sit in five 8-bit APB registers at byte addresses
// 0x00..0x10; change them only while the block is idle. Rate: one item per
// clock while the output is not stalled; an item is registered in the input
// register, and its result is loaded into the output register once the output
// register is free. The per-byte CRC update is an unrolled eight-step shift
// over the byte that leaves a four-byte tail window, which keeps the CRC bytes
// and end bytes out of the sum without any look-ahead. Stall on the output
// side backs up through the input register.
module uart_frame_deframer_crc16 import ufd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  // APB config
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  cfg_t cfg;

  ufd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register and stage advance
  // ---------------------------------------------------------------------------
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     advance;  // output register free to take the next result
  logic     proc;     // item in the input register is consumed this cycle

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign proc       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       tail_q [4];
  logic [7:0]       tail_d [4];
  logic [15:0]      len_q, len_d;
  logic             start_ok_q, start_ok_d;
  logic             version_ok_q, version_ok_d;
  logic [7:0]       hdr_q [HDR_LO:HDR_HI];

  logic [7:0] b;
  logic       last;

  assign b    = in_item_q.frame_byte;
  assign last = in_item_q.last_byte;

  // Header bytes: each one captured at its own fixed offset.
  always_ff @(posedge clk_i) begin
    for (int k = HDR_LO; k <= HDR_HI; k++) begin
      if (proc && pos_q == POS_W'(k)) begin
        hdr_q[k] <= b;
      end
    end
  end

  // Per-byte update, before the end-of-frame clear.
  logic [15:0] crc_upd;
  logic        start_ok_upd, version_ok_upd;

  always_comb begin
    start_ok_upd = start_ok_q;
    if (pos_q == OFS_START_0 && b != cfg.start_byte_0) start_ok_upd = 1'b0;
    if (pos_q == OFS_START_1 && b != cfg.start_byte_1) start_ok_upd = 1'b0;
    version_ok_upd = version_ok_q;
    if (pos_q == OFS_VERSION && b != cfg.protocol_version) version_ok_upd = 1'b0;

    len_d = len_q;
    if (pos_q == OFS_LEN_LO) len_d[7:0]  = b;
    if (pos_q == OFS_LEN_HI) len_d[15:8] = b;

    // tail_q[0] is the oldest byte; it leaves the window and enters the CRC
    tail_d[0] = tail_q[1];
    tail_d[1] = tail_q[2];
    tail_d[2] = tail_q[3];
    tail_d[3] = b;
    crc_upd = (pos_q >= OFS_CRC_START) ? crc16_byte(crc_q, tail_q[0]) : crc_q;
  end

  // ---------------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------------
  status_e     status;
  logic [15:0] rx_crc;
  logic [16:0] want_last_pos;
  logic [15:0] pay_idx;
  logic        is_payload;
  out_item_t   res;

  assign rx_crc        = {tail_q[2], tail_q[1]};
  assign want_last_pos = 17'(MIN_LAST_POS) + {1'b0, len_q};
  assign pay_idx       = 16'(pos_q - OFS_PAYLOAD);
  assign is_payload    = !last && pos_q >= OFS_PAYLOAD && pay_idx < len_q;

  always_comb begin
    if (pos_q >= POS_MAX || pos_q < MIN_LAST_POS) begin
      status = ST_BAD_LENGTH;
    end else if (!start_ok_upd) begin
      status = ST_BAD_START;
    end else if (!version_ok_upd) begin
      status = ST_BAD_VERSION;
    end else if (len_q > MAX_LEN || {6'd0, pos_q} != want_last_pos) begin
      status = ST_BAD_LENGTH;
    end else if (tail_q[3] != cfg.end_byte_0 || b != cfg.end_byte_1) begin
      status = ST_BAD_END;
    end else if (crc_upd != rx_crc) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res = '0;
    if (last) begin
      res.is_summary = 1'b1;
      res.status     = status;
      if (status == ST_OK) begin
        res.msg_type        = hdr_q[3];
        res.frame_flags     = hdr_q[4];
        res.sequence_res    = {hdr_q[6], hdr_q[5]};
        res.session         = {hdr_q[10], hdr_q[9], hdr_q[8], hdr_q[7]};
        res.device          = {hdr_q[14], hdr_q[13], hdr_q[12], hdr_q[11]};
        res.endpoint_number = {hdr_q[16], hdr_q[15]};
        res.binding_rev     = {hdr_q[20], hdr_q[19], hdr_q[18], hdr_q[17]};
        res.cluster_code    = {hdr_q[24], hdr_q[23], hdr_q[22], hdr_q[21]};
        res.item_code       = {hdr_q[28], hdr_q[27], hdr_q[26], hdr_q[25]};
      end
    end else begin
      res.payload_byte = b;
    end
  end

  // Next state: end of frame returns position, CRC and check flags to idle values.
  always_comb begin
    if (last) begin
      pos_d        = '0;
      crc_d        = CRC_INIT;
      start_ok_d   = 1'b1;
      version_ok_d = 1'b1;
    end else begin
      pos_d        = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
      crc_d        = crc_upd;
      start_ok_d   = start_ok_upd;
      version_ok_d = version_ok_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      crc_q        <= CRC_INIT;
      len_q        <= '0;
      start_ok_q   <= 1'b1;
      version_ok_q <= 1'b1;
      for (int i = 0; i < 4; i++) tail_q[i] <= '0;
    end else if (proc) begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      start_ok_q   <= start_ok_d;
      version_ok_q <= version_ok_d;
      if (last) begin
        len_q <= '0;
        for (int i = 0; i < 4; i++) tail_q[i] <= '0;
      end else begin
        len_q <= len_d;
        for (int i = 0; i < 4; i++) tail_q[i] <= tail_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= proc && (last || is_payload);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
